>>> rtl/core/tks_pkg.sv
package tks_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int ROW_W        = 32;
	localparam int NUM_ROWS     = 32;
	localparam int IDX_W        = 5;
	localparam int CNT_W        = 6;
	// Vertices that can take part in a sort: bounded by the row width as well.
	localparam int EFF_MAX      = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEG,
		ST_SEL,
		ST_UPD
	} tks_state_t;

	typedef struct packed {
		logic             clear;
		logic             add;
		logic             sub;
		logic             mark;
		logic [IDX_W-1:0] mark_idx;
	} deg_ctrl_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} deg_stat_t;

endpackage

>>> rtl/core/tks_if.sv
interface tks_row_if;
	import tks_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] row_index;
	logic [ROW_W-1:0] row_bits;
	logic             last_row;

	modport source (output valid, output row_index, output row_bits, output last_row,
		input ready);
	modport sink (input valid, input row_index, input row_bits, input last_row,
		output ready);
endinterface

interface tks_ord_if;
	import tks_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] vertex;
	logic             last;
	logic             incomplete;

	modport source (output valid, output vertex, output last, output incomplete,
		input ready);
	modport sink (input valid, input vertex, input last, input incomplete,
		output ready);
endinterface

interface tks_cfg_if;
	import tks_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tks_ram.sv
module tks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/tks_degree.sv
module tks_degree (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tks_pkg::deg_ctrl_t           ctrl,
	input  logic [tks_pkg::ROW_W-1:0]    row_data,
	input  logic [tks_pkg::ROW_W-1:0]    lane_mask,
	output tks_pkg::deg_stat_t           stat
);
	import tks_pkg::*;

	logic [CNT_W-1:0] count_q [ROW_W];
	logic [ROW_W-1:0] emitted_q;
	logic [ROW_W-1:0] edges;
	logic [ROW_W-1:0] rdy;
	logic [ROW_W-1:0] first;
	logic [IDX_W-1:0] idx;

	assign edges = row_data & lane_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_W; i++) begin
				count_q[i] <= '0;
			end
			emitted_q <= '0;
		end else begin
			if (ctrl.clear) begin
				for (int i = 0; i < ROW_W; i++) begin
					count_q[i] <= '0;
				end
				emitted_q <= '0;
			end else begin
				for (int i = 0; i < ROW_W; i++) begin
					if (ctrl.add && edges[i]) begin
						count_q[i] <= count_q[i] + CNT_W'(1);
					end else if (ctrl.sub && edges[i] && count_q[i] != '0) begin
						count_q[i] <= count_q[i] - CNT_W'(1);
					end
				end
				if (ctrl.mark) begin
					emitted_q[ctrl.mark_idx] <= 1'b1;
				end
			end
		end
	end

	// Isolate the lowest ready lane, then encode it with an OR per index bit.
	always_comb begin
		for (int i = 0; i < ROW_W; i++) begin
			rdy[i] = lane_mask[i] && !emitted_q[i] && (count_q[i] == '0);
		end
		first = rdy & (~rdy + ROW_W'(1));
		idx = '0;
		for (int i = 0; i < ROW_W; i++) begin
			if (first[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		stat.found = |rdy;
		stat.idx   = idx;
	end

endmodule

>>> rtl/core/topological_sort_kahn_min_index_core.sv
// Channel  | Dir | Word                               | Notes
// rows     | in  | row_index, row_bits, last_row      | one adjacency row per word
// order    | out | vertex, last, incomplete           | 1-based vertex, 0 if none
// cfg      | in  | data = vertex_count                | always ready, write when idle
//
// Rows are taken one per cycle while no sort runs; each is written to the row RAM.
// After a word with last_row, the in-degree pass reads n rows. Each ordered vertex then
// passes through select, then successor update through the RAM read port, and a closing
// select ends the sort. A full output register holds the sequencer in select unless a
// vertex is found while none is pending. Reset clears counts, flags and state and sets
// the vertex count to 32; the row RAM is not cleared and must be written before it is
// used.
module topological_sort_kahn_min_index_core (
	input logic clk,
	input logic arst_n,
	tks_row_if.sink   rows,
	tks_ord_if.source order,
	tks_cfg_if.sink   cfg
);
	import tks_pkg::*;

	tks_state_t       state_q, state_d;
	logic [CNT_W-1:0] vcount_q;
	logic [CNT_W-1:0] eff_n;
	logic [ROW_W-1:0] lane_mask;
	logic [CNT_W-1:0] rd_q;
	logic             rdv_s1;
	logic [CNT_W-1:0] emit_cnt_q;
	logic             pend_valid_q;
	logic [CNT_W-1:0] pend_vtx_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] out_vertex_q;
	logic             out_last_q;
	logic             out_inc_q;

	logic             row_acc;
	logic             start;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [ROW_W-1:0] ram_rdata;
	deg_ctrl_t        dctrl;
	deg_stat_t        dstat;
	logic             slot_free;
	logic             push;
	logic [CNT_W-1:0] push_vertex;
	logic             push_last;
	logic             push_inc;
	logic             take;

	assign cfg.ready = 1'b1;

	assign rows.ready = (state_q == ST_IDLE);
	assign row_acc    = rows.valid && rows.ready;
	assign start      = row_acc && rows.last_row;

	assign order.valid      = out_valid_q;
	assign order.vertex     = out_vertex_q;
	assign order.last       = out_last_q;
	assign order.incomplete = out_inc_q;
	assign slot_free        = !out_valid_q || order.ready;

	assign eff_n = (vcount_q > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : vcount_q;

	always_comb begin
		for (int i = 0; i < ROW_W; i++) begin
			lane_mask[i] = (CNT_W'(i) < eff_n);
		end
	end

	tks_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_ROWS)
	) u_rows (
		.clk  (clk),
		.we   (row_acc),
		.waddr(rows.row_index),
		.wdata(rows.row_bits),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tks_degree u_degree (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dctrl),
		.row_data (ram_rdata),
		.lane_mask(lane_mask),
		.stat     (dstat)
	);

	always_comb begin
		state_d        = state_q;
		ram_re         = 1'b0;
		ram_raddr      = rd_q[IDX_W-1:0];
		dctrl.clear    = start;
		dctrl.add      = 1'b0;
		dctrl.sub      = 1'b0;
		dctrl.mark     = 1'b0;
		dctrl.mark_idx = dstat.idx;
		push           = 1'b0;
		push_vertex    = pend_vtx_q;
		push_last      = 1'b0;
		push_inc       = 1'b0;
		take           = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DEG;
				end
			end
			ST_DEG: begin
				ram_re    = (rd_q < eff_n);
				dctrl.add = rdv_s1;
				if (!ram_re && !rdv_s1) begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				// A vertex is sent only once the next select shows whether it ends the order.
				if ((dstat.found && !pend_valid_q) || slot_free) begin
					take = 1'b1;
					if (dstat.found) begin
						push       = pend_valid_q;
						dctrl.mark = 1'b1;
						ram_re     = 1'b1;
						ram_raddr  = dstat.idx;
						state_d    = ST_UPD;
					end else begin
						push      = 1'b1;
						push_last = 1'b1;
						if (pend_valid_q) begin
							push_inc = (emit_cnt_q < eff_n);
						end else begin
							push_vertex = '0;
							push_inc    = (eff_n != '0);
						end
						state_d = ST_IDLE;
					end
				end
			end
			ST_UPD: begin
				dctrl.sub = 1'b1;
				state_d   = ST_SEL;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= CNT_W'(32);
			rd_q         <= '0;
			rdv_s1       <= 1'b0;
			emit_cnt_q   <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				vcount_q <= cfg.data;
			end
			rdv_s1 <= (state_q == ST_DEG) && ram_re;
			if (start) begin
				rd_q         <= '0;
				emit_cnt_q   <= '0;
				pend_valid_q <= 1'b0;
			end else if (state_q == ST_DEG && ram_re) begin
				rd_q <= rd_q + CNT_W'(1);
			end
			if (take && dstat.found) begin
				emit_cnt_q   <= emit_cnt_q + CNT_W'(1);
				pend_valid_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (order.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && dstat.found) begin
			pend_vtx_q <= CNT_W'(dstat.idx) + CNT_W'(1);
		end
		if (push) begin
			out_vertex_q <= push_vertex;
			out_last_q   <= push_last;
			out_inc_q    <= push_inc;
		end
	end

endmodule
